// ===== design/lppd_pkg.sv =====
// Shared types and constants for the length-prefixed packet deframer.
// No dependencies; every other file in the block refers to this package.
package lppd_pkg;

    // Timestamp size in bytes (seconds word then microseconds word)
    localparam int STAMP_BYTES_DEF = 16;

    // Microseconds per second and the widths of the split delay
    localparam logic [31:0] USEC_PER_SEC = 32'd1000000;
    localparam int QUO_BITS = 13;   // 2^32 / 1e6 < 2^13
    localparam int REM_BITS = 20;   // remainder < 1e6 < 2^20

    // Queue between parser and output stage
    localparam int QUEUE_DEPTH = 2;

    // Port widths
    localparam int CFG_DATA_W = 32;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 152; // byte, seconds, microseconds, length
    localparam int M_USER_W   = 3;   // start, empty, error

    // Configuration register indexes
    typedef enum logic {
        CFG_RTT_USEC   = 1'b0,
        CFG_ADD_DELAY  = 1'b1
    } t_cfg_index;

    // Parser phase
    typedef enum logic [1:0] {
        PH_LEN_LO  = 2'd0,
        PH_LEN_HI  = 2'd1,
        PH_STAMP   = 2'd2,
        PH_PAYLOAD = 2'd3
    } t_phase;

    // One request passed from the parser to the output stage
    typedef struct packed {
        logic [7:0]  payload;
        logic        first;
        logic        last;
        logic        empty;
        logic        error;
        logic [15:0] plen;
        logic [63:0] sec;
        logic [63:0] usec;
    } t_entry;

    // Delay settings handed to the output stage
    typedef struct packed {
        logic                enable;
        logic [QUO_BITS-1:0] secs;
        logic [REM_BITS-1:0] usecs;
    } t_delay;

endpackage

// ===== design/length_prefixed_packet_deframer.sv =====
// Length-prefixed packet deframer, top level.
// Depends on lppd_pkg, lppd_delay, lppd_front, lppd_fifo and lppd_back.
//
// Usage:
//   Slave stream: one decrypted record byte per request, tlast on the last
//   byte of each record. Master stream: one request per payload byte with
//   the packet timestamp and payload length; tlast marks the packet's last
//   byte, tuser flags packet start, a timestamp-only packet and a length
//   field shorter than the timestamp.
//   Throughput is one byte per cycle while tready is high; a result passes
//   through the request queue and the output register before it is valid
//   on the master side. Bytes that give no result (length, timestamp,
//   skipped bytes) are consumed at the same rate.
//   Writing the delay register starts a split into seconds and
//   microseconds by reciprocal multiplication, quotient then remainder;
//   tready is low until both are set. Writing the enable takes effect at once.
//   A stalled receiver holds the output register; the parser keeps taking
//   bytes until the two-deep request queue fills, then drops tready.
//   Reset (synchronous, active low) returns the parser to waiting for a
//   length low byte, empties queue and output, and clears the delay.
module length_prefixed_packet_deframer #(
    parameter int STAMP_BYTES = lppd_pkg::STAMP_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_index,
    input  logic [lppd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // slave stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [lppd_pkg::S_DATA_W-1:0]   i_s_tdata,  // [7:0] record_byte
    input  logic                            i_s_tlast,  // record_end
    // master stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [7:0] payload_byte, [71:8] stamp_seconds, [135:72] stamp_microseconds,
    // [151:136] packet_length
    output logic [lppd_pkg::M_DATA_W-1:0]   o_m_tdata,
    // [0] packet_start, [1] empty_packet, [2] length_error
    output logic [lppd_pkg::M_USER_W-1:0]   o_m_tuser,
    output logic                            o_m_tlast   // packet_end
);

    logic             w_busy;
    lppd_pkg::t_delay w_delay;
    logic             w_accept;
    logic             w_push;
    lppd_pkg::t_entry w_push_entry;
    logic             w_full;
    logic             w_q_valid;
    lppd_pkg::t_entry w_q_entry;
    logic             w_pop;

    // take a byte only when the queue has room and the delay split is done
    assign o_s_tready = !w_full && !w_busy;
    assign w_accept   = i_s_tvalid && o_s_tready;

    lppd_delay u_delay (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_busy      (w_busy),
        .o_delay     (w_delay)
    );

    lppd_front #(
        .STAMP_BYTES (STAMP_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_byte    (i_s_tdata),
        .i_rec_end (i_s_tlast),
        .o_push    (w_push),
        .o_entry   (w_push_entry)
    );

    lppd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry)
    );

    lppd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .i_entry    (w_q_entry),
        .i_delay    (w_delay),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ===== design/lppd_delay.sv =====
// Configuration registers and the seconds/microseconds split of the delay.
// Depends on lppd_pkg; reciprocal multiplication gives the quotient, registered before the remainder.
module lppd_delay (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_index,
    input  logic [lppd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                             o_busy,
    output lppd_pkg::t_delay                 o_delay
);

    localparam int          QB    = lppd_pkg::QUO_BITS;
    localparam int          RB    = lppd_pkg::REM_BITS;
    // 1e6 = 64 * 15625; ceil(2^40 / 15625) is exact for 26-bit dividends
    localparam logic [26:0] RECIP = 27'd70368745;

    logic              r_enable,  n_enable;
    logic [31:0]       r_rtt,     n_rtt;
    logic              r_quo_due, n_quo_due;
    logic              r_rem_due, n_rem_due;
    logic [QB-1:0]     r_quo,     n_quo;
    logic [RB-1:0]     r_rem,     n_rem;
    logic [52:0]       w_prod;
    logic [QB-1:0]     w_quo;
    logic [31:0]       w_rem;

    // quotient from the registered delay, remainder from the registered quotient
    assign w_prod = 53'(r_rtt[31:6]) * 53'(RECIP);
    assign w_quo  = w_prod[52:40];
    assign w_rem  = r_rtt - (32'(r_quo) * lppd_pkg::USEC_PER_SEC);

    always_comb begin
        n_enable  = r_enable;
        n_rtt     = r_rtt;
        n_quo_due = 1'b0;
        n_rem_due = r_quo_due;
        n_quo     = r_quo;
        n_rem     = r_rem;
        if (r_quo_due) begin
            n_quo = w_quo;
        end
        if (r_rem_due) begin
            n_rem = w_rem[RB-1:0];
        end
        if (i_cfg_we) begin
            case (lppd_pkg::t_cfg_index'(i_cfg_index))
                lppd_pkg::CFG_RTT_USEC: begin
                    n_rtt     = i_cfg_data;
                    n_quo_due = 1'b1;
                    n_rem_due = 1'b0;
                end
                lppd_pkg::CFG_ADD_DELAY: begin
                    n_enable = i_cfg_data[0];
                end
                default: begin
                    n_enable = r_enable;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_rtt     <= '0;
            r_quo_due <= 1'b0;
            r_rem_due <= 1'b0;
            r_quo     <= '0;
            r_rem     <= '0;
        end else begin
            r_enable  <= n_enable;
            r_rtt     <= n_rtt;
            r_quo_due <= n_quo_due;
            r_rem_due <= n_rem_due;
            r_quo     <= n_quo;
            r_rem     <= n_rem;
        end
    end

    assign o_busy         = r_quo_due || r_rem_due;
    assign o_delay.enable = r_enable;
    assign o_delay.secs   = r_quo;
    assign o_delay.usecs  = r_rem;

endmodule

// ===== design/lppd_front.sv =====
// Parser: walks length, timestamp and payload bytes and builds requests.
// Depends on lppd_pkg; pushes at most one request per accepted byte.
module lppd_front #(
    parameter int STAMP_BYTES = lppd_pkg::STAMP_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    input  logic             i_rec_end,
    output logic             o_push,
    output lppd_pkg::t_entry o_entry
);

    localparam logic [15:0] STAMP_LEN = 16'(STAMP_BYTES);

    lppd_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_len_low, n_len_low;
    logic [15:0]      r_frame,   n_frame;
    logic [15:0]      r_cnt,     n_cnt;
    logic [63:0]      r_stamp [2];
    logic [63:0]      n_stamp [2];

    logic [15:0] w_new_frame;
    logic [15:0] w_cnt_inc;
    logic        w_short;
    logic        w_new_short;
    logic        w_stamp_done;

    assign w_new_frame  = {i_byte, r_len_low};
    assign w_cnt_inc    = r_cnt + 16'd1;
    assign w_short      = (r_frame < STAMP_LEN);
    assign w_new_short  = (w_new_frame < STAMP_LEN);
    assign w_stamp_done = (w_cnt_inc >= STAMP_LEN);

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            case (r_phase)
                lppd_pkg::PH_LEN_LO: begin
                    if (!i_rec_end) begin
                        n_phase = lppd_pkg::PH_LEN_HI;
                    end
                end
                lppd_pkg::PH_LEN_HI: begin
                    n_phase = (w_new_frame == '0) ? lppd_pkg::PH_LEN_LO
                                                  : lppd_pkg::PH_STAMP;
                end
                lppd_pkg::PH_STAMP: begin
                    if (w_short) begin
                        if (w_cnt_inc >= r_frame) begin
                            n_phase = lppd_pkg::PH_LEN_LO;
                        end
                    end else if (w_stamp_done) begin
                        n_phase = (r_frame == STAMP_LEN) ? lppd_pkg::PH_LEN_LO
                                                         : lppd_pkg::PH_PAYLOAD;
                    end
                end
                lppd_pkg::PH_PAYLOAD: begin
                    if (w_cnt_inc >= r_frame) begin
                        n_phase = lppd_pkg::PH_LEN_LO;
                    end
                end
                default: begin
                    n_phase = lppd_pkg::PH_LEN_LO;
                end
            endcase
        end
    end

    // Datapath and request
    always_comb begin
        n_len_low  = r_len_low;
        n_frame    = r_frame;
        n_cnt      = r_cnt;
        n_stamp[0] = r_stamp[0];
        n_stamp[1] = r_stamp[1];
        o_push     = 1'b0;
        o_entry    = '0;
        if (i_accept) begin
            case (r_phase)
                lppd_pkg::PH_LEN_LO: begin
                    if (!i_rec_end) begin
                        n_len_low = i_byte;
                    end
                end
                lppd_pkg::PH_LEN_HI: begin
                    n_frame    = w_new_frame;
                    n_cnt      = '0;
                    n_stamp[0] = '0;
                    n_stamp[1] = '0;
                    if (w_new_short) begin
                        o_push        = 1'b1;
                        o_entry.error = 1'b1;
                    end
                end
                lppd_pkg::PH_STAMP: begin
                    n_cnt = w_cnt_inc;
                    if (!w_short) begin
                        n_stamp[r_cnt[3]][{r_cnt[2:0], 3'b000} +: 8] = i_byte;
                        if (w_stamp_done && (r_frame == STAMP_LEN)) begin
                            // timestamp-only packet
                            o_push        = 1'b1;
                            o_entry.first = 1'b1;
                            o_entry.last  = 1'b1;
                            o_entry.empty = 1'b1;
                            o_entry.sec   = n_stamp[0];
                            o_entry.usec  = n_stamp[1];
                        end
                    end
                end
                lppd_pkg::PH_PAYLOAD: begin
                    n_cnt           = w_cnt_inc;
                    o_push          = 1'b1;
                    o_entry.payload = i_byte;
                    o_entry.first   = (r_cnt == STAMP_LEN);
                    o_entry.last    = (w_cnt_inc >= r_frame);
                    o_entry.plen    = r_frame - STAMP_LEN;
                    o_entry.sec     = r_stamp[0];
                    o_entry.usec    = r_stamp[1];
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= lppd_pkg::PH_LEN_LO;
            r_len_low  <= '0;
            r_frame    <= '0;
            r_cnt      <= '0;
            r_stamp[0] <= '0;
            r_stamp[1] <= '0;
        end else begin
            r_phase    <= n_phase;
            r_len_low  <= n_len_low;
            r_frame    <= n_frame;
            r_cnt      <= n_cnt;
            r_stamp[0] <= n_stamp[0];
            r_stamp[1] <= n_stamp[1];
        end
    end

endmodule

// ===== design/lppd_fifo.sv =====
// Short request queue between the parser and the output stage.
// Depends on lppd_pkg for the request type and depth.
module lppd_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lppd_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output lppd_pkg::t_entry o_entry
);

    localparam int DEPTH = lppd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    lppd_pkg::t_entry r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

// ===== design/lppd_back.sv =====
// Output stage: adds the split delay to the timestamp when enabled (not for error requests) and holds the result.
// Depends on lppd_pkg; a single output register decouples the receiver.
module lppd_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  lppd_pkg::t_entry               i_entry,
    input  lppd_pkg::t_delay               i_delay,
    output logic                           o_pop,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [lppd_pkg::M_DATA_W-1:0]  o_m_tdata,
    output logic [lppd_pkg::M_USER_W-1:0]  o_m_tuser,
    output logic                           o_m_tlast
);

    logic             r_valid, n_valid;
    lppd_pkg::t_entry r_out;
    lppd_pkg::t_entry w_next;
    logic             w_add;
    logic [63:0]      w_sec_add;
    logic [63:0]      w_usec_add;

    assign o_pop = i_valid && (!r_valid || i_m_tready);
    assign w_add = i_delay.enable && !i_entry.error;

    assign w_sec_add  = w_add ? 64'(i_delay.secs)  : '0;
    assign w_usec_add = w_add ? 64'(i_delay.usecs) : '0;

    always_comb begin
        w_next      = i_entry;
        w_next.sec  = i_entry.sec  + w_sec_add;
        w_next.usec = i_entry.usec + w_usec_add;
    end

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_m_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= w_next;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {r_out.plen, r_out.usec, r_out.sec, r_out.payload};
    assign o_m_tuser  = {r_out.error, r_out.empty, r_out.first};
    assign o_m_tlast  = r_out.last;

endmodule
